// File: hw/rtl/sus_pkg.sv
// shared types and constants for the sorted unique set table
package sus_pkg;

   localparam int DEPTH   = 16;
   localparam int VALUE_W = 32;
   localparam int CNT_W   = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_DUMP   = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_DELETED   = 3'd3,
      ST_NOTFOUND  = 3'd4,
      ST_DUMP      = 3'd5
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_DUMP = 1'b1
   } fsm_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_ROTATE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        valid;
      logic        tail;
   } cell_ctl_type;

endpackage

// File: hw/rtl/sorted_unique_set_table.sv
// Sorted set of up to DEPTH signed 32-bit values held in a chain of compare/shift
// cells. On an insert or delete every cell compares the request value at once and
// shifts toward or from its neighbor. On a dump the chain rotates one place per
// cycle while the output is not stalled and the head cell is sent out, so after a full
// dump the order is restored; an empty table gives one zero result. Requests
// are stalled during a dump and while a result waits on a stalled output. No clearing
// pass is needed after reset; the entry count alone marks which cells hold data.
module sorted_unique_set_table
   import sus_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_command,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_status,
   output logic signed [VALUE_W-1:0] rsp_entry,
   output logic                      rsp_empty_res,
   output logic                      rsp_last
);

   fsm_type                   state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                status_ff, status_in;
   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      empty_ff, empty_in;
   logic                      last_ff, last_in;

   logic                      accept;
   logic                      out_free;
   logic                      load;
   logic                      any_eq;
   logic                      full;
   logic                      dump_last;
   cell_op_type               op;

   cell_ctl_type              ctl  [DEPTH];
   logic signed [VALUE_W-1:0] data [DEPTH];
   logic                      take [DEPTH];
   logic [DEPTH-1:0]          eq;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == FSM_DUMP) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign any_eq    = |eq;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign dump_last = (idx_ff == count_ff - CNT_W'(1));

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign ctl[i].op    = op;
      assign ctl[i].valid = (CNT_W'(i) < count_ff);
      assign ctl[i].tail  = (CNT_W'(i) == count_ff - CNT_W'(1));

      sus_cell u_cell (
         .clock      (clock),
         .ctl        (ctl[i]),
         .value      (req_value),
         .left_take  ((i == 0) ? 1'b0 : take[(i == 0) ? 0 : i - 1]),
         .left_data  (data[(i == 0) ? 0 : i - 1]),
         .right_data (data[(i == DEPTH - 1) ? i : i + 1]),
         .head_data  (data[0]),
         .data       (data[i]),
         .take       (take[i]),
         .eq         (eq[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept && (req_command == CMD_DUMP) && (count_ff != '0)) begin
               state_in = FSM_DUMP;
            end
         end
         FSM_DUMP: begin
            if (out_free && dump_last) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      op        = OP_HOLD;
      load      = 1'b0;
      count_in  = count_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      entry_in  = entry_ff;
      empty_in  = 1'b0;
      last_in   = 1'b1;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               entry_in = req_value;
               case (req_command)
                  CMD_INSERT: begin
                     load = 1'b1;
                     if (any_eq) begin
                        status_in = ST_DUPLICATE;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        status_in = ST_INSERTED;
                        op        = OP_INSERT;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_DELETE: begin
                     load = 1'b1;
                     if (any_eq) begin
                        status_in = ST_DELETED;
                        op        = OP_DELETE;
                        count_in  = count_ff - CNT_W'(1);
                     end else begin
                        status_in = ST_NOTFOUND;
                     end
                  end
                  CMD_DUMP: begin
                     idx_in = '0;
                     if (count_ff == '0) begin
                        load      = 1'b1;
                        status_in = ST_DUMP;
                        entry_in  = '0;
                        empty_in  = 1'b1;
                     end
                  end
                  default: begin
                     load = 1'b0;
                  end
               endcase
            end
         end
         FSM_DUMP: begin
            if (out_free) begin
               load      = 1'b1;
               op        = OP_ROTATE;
               status_in = ST_DUMP;
               entry_in  = data[0];
               last_in   = dump_last;
               idx_in    = idx_ff + CNT_W'(1);
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         entry_ff  <= entry_in;
         empty_ff  <= empty_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_entry     = entry_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_last      = last_ff;

endmodule

// File: hw/rtl/sus_cell.sv
// one cell of the sorted chain: holds one entry, compares and shifts
module sus_cell
   import sus_pkg::*;
(
   input  logic                      clock,
   input  cell_ctl_type              ctl,
   input  logic signed [VALUE_W-1:0] value,
   input  logic                      left_take,
   input  logic signed [VALUE_W-1:0] left_data,
   input  logic signed [VALUE_W-1:0] right_data,
   input  logic signed [VALUE_W-1:0] head_data,
   output logic signed [VALUE_W-1:0] data,
   output logic                      take,
   output logic                      eq
);

   logic signed [VALUE_W-1:0] data_ff;
   logic signed [VALUE_W-1:0] data_in;
   logic                      shift_del;

   assign data      = data_ff;
   assign eq        = ctl.valid && (data_ff == value);
   // insert point or beyond: empty, or holding something larger
   assign take      = !ctl.valid || (data_ff > value);
   // delete closes the gap from the match upward
   assign shift_del = ctl.valid && (data_ff >= value);

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         OP_INSERT: begin
            if (take && left_take) begin
               data_in = left_data;
            end else if (take) begin
               data_in = value;
            end
         end
         OP_DELETE: begin
            if (shift_del) begin
               data_in = right_data;
            end
         end
         OP_ROTATE: begin
            if (ctl.valid) begin
               data_in = ctl.tail ? head_data : right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// File: hw/rtl/sus_checker.sv
// port-level checks for the sorted unique set table, bound to the top level
module sus_checker
   import sus_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [2:0]                rsp_status,
   input logic signed [VALUE_W-1:0] rsp_entry,
   input logic                      rsp_empty_res,
   input logic                      rsp_last
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_entry) && $stable(rsp_status))
      else $error("stalled response changed");

   // mid-dump the request side stays blocked
   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_DUMP) && !rsp_last |-> req_stall)
      else $error("request accepted during dump");

   // insert and delete give a single result
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DUMP) |-> rsp_last && !rsp_empty_res)
      else $error("insert or delete result not single");

   // an empty dump is one zero result
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last && (rsp_entry == '0)
                                     && (rsp_status == ST_DUMP))
      else $error("bad empty dump result");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sorted_unique_set_table sus_checker u_sus_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_entry     (rsp_entry),
   .rsp_empty_res (rsp_empty_res),
   .rsp_last      (rsp_last)
);
